// File: sv/thfd_pkg.sv
// Shared types and constants for the temperature and humidity frame decoder.
// Used by the front end, the job queue and the back end; no dependencies.
`timescale 1ns / 1ps

package thfd_pkg;

    // Status codes of a result item.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_READ_FAIL = 2'd1;
    localparam logic [1:0] ST_CRC_BAD   = 2'd2;

    // CRC-8 settings of the sensor frame.
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Conversion constants.
    localparam int unsigned TEMP_SPAN   = 1750;
    localparam int unsigned HUM_SPAN    = 1000;
    localparam int unsigned TEMP_OFFSET = 450;
    localparam int unsigned FULL_SCALE  = 65535;

    // One job handed from the front end to the back end.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] raw_temp;
        logic [15:0] raw_hum;
    } t_job;

endpackage

// File: sv/thfd_if.sv
// Handshake channels of the frame decoder: the byte input and the result output.
// Depends on nothing.
`timescale 1ns / 1ps

interface thfd_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface thfd_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [11:0] temp_deci;
    logic [9:0]         rh_permille;

    modport source (output valid, output status, output temp_deci,
                    output rh_permille, input ready);
    modport sink   (input valid, input status, input temp_deci,
                    input rh_permille, output ready);
endinterface

// File: sv/thfd_front.sv
// Front end: tracks the frame, runs the CRC; one job per frame or read failure.
// Depends on thfd_pkg.
`timescale 1ns / 1ps

module thfd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic           i_op,
    input  logic [7:0]     i_data_byte,
    output logic           o_push,
    output thfd_pkg::t_job o_job
);

    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    logic [2:0]  r_pos,  n_pos;
    logic [7:0]  r_crc,  n_crc;
    logic        r_t_ok, n_t_ok;
    logic [15:0] r_raw_t, n_raw_t;
    logic [15:0] r_raw_h, n_raw_h;
    logic [2:0]  pos_eff;

    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ thfd_pkg::CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    always_comb begin
        n_pos   = r_pos;
        n_crc   = r_crc;
        n_t_ok  = r_t_ok;
        n_raw_t = r_raw_t;
        n_raw_h = r_raw_h;
        o_push  = 1'b0;
        o_job.status   = thfd_pkg::ST_OK;
        o_job.raw_temp = r_raw_t;
        o_job.raw_hum  = r_raw_h;
        pos_eff = (r_pos > POS_H_CRC) ? POS_T_HI : r_pos;

        if (i_accept) begin
            if (i_op) begin
                n_pos  = POS_T_HI;
                n_crc  = thfd_pkg::CRC_INIT;
                n_t_ok = 1'b0;
                o_push = 1'b1;
                o_job.status = thfd_pkg::ST_READ_FAIL;
            end else begin
                n_pos = pos_eff + 3'd1;
                case (pos_eff)
                    POS_T_HI: begin
                        n_crc   = crc_feed(thfd_pkg::CRC_INIT, i_data_byte);
                        n_raw_t = {i_data_byte, r_raw_t[7:0]};
                        n_t_ok  = (r_pos > POS_H_CRC) ? 1'b0 : r_t_ok;
                    end
                    POS_T_LO: begin
                        n_crc   = crc_feed(r_crc, i_data_byte);
                        n_raw_t = {r_raw_t[15:8], i_data_byte};
                    end
                    POS_T_CRC: begin
                        n_t_ok = (r_crc == i_data_byte);
                        n_crc  = thfd_pkg::CRC_INIT;
                    end
                    POS_H_HI: begin
                        n_crc   = crc_feed(thfd_pkg::CRC_INIT, i_data_byte);
                        n_raw_h = {i_data_byte, r_raw_h[7:0]};
                    end
                    POS_H_LO: begin
                        n_crc   = crc_feed(r_crc, i_data_byte);
                        n_raw_h = {r_raw_h[15:8], i_data_byte};
                    end
                    default: begin
                        // Last check byte: the frame closes and yields one job.
                        n_pos  = POS_T_HI;
                        n_crc  = thfd_pkg::CRC_INIT;
                        n_t_ok = 1'b0;
                        o_push = 1'b1;
                        o_job.status = (r_t_ok && (r_crc == i_data_byte)) ?
                                       thfd_pkg::ST_OK : thfd_pkg::ST_CRC_BAD;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_T_HI;
            r_crc   <= thfd_pkg::CRC_INIT;
            r_t_ok  <= 1'b0;
            r_raw_t <= 16'd0;
            r_raw_h <= 16'd0;
        end else begin
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_t_ok  <= n_t_ok;
            r_raw_t <= n_raw_t;
            r_raw_h <= n_raw_h;
        end
    end

endmodule

// File: sv/thfd_queue.sv
// Small first-in first-out queue of jobs between the front end and the back end.
// Depends on thfd_pkg.
`timescale 1ns / 1ps

module thfd_queue #(
    parameter int P_DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  thfd_pkg::t_job i_job,
    input  logic           i_pop,
    output thfd_pkg::t_job o_job,
    output logic           o_full,
    output logic           o_empty
);

    localparam int IW = $clog2(P_DEPTH);
    localparam int CW = $clog2(P_DEPTH + 1);

    thfd_pkg::t_job r_mem [P_DEPTH];
    logic [IW-1:0]  r_wr, n_wr;
    logic [IW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == CW'(P_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == IW'(P_DEPTH - 1)) ? '0 : r_wr + IW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == IW'(P_DEPTH - 1)) ? '0 : r_rd + IW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// File: sv/thfd_back.sv
// Back end: scales the raw words, keeps the last good readings, holds the result.
// Depends on thfd_pkg.
`timescale 1ns / 1ps

module thfd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  thfd_pkg::t_job     i_job,
    output logic               o_job_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic signed [11:0] o_temp_deci,
    output logic [9:0]         o_rh_permille
);

    // Product stage.
    logic        r_a_valid;
    logic [1:0]  r_a_status;
    logic [26:0] r_a_prod_t;
    logic [25:0] r_a_prod_h;

    // Kept readings and the output register.
    logic [10:0]        r_last_t, n_last_t;
    logic [9:0]         r_last_h, n_last_h;
    logic               r_o_valid;
    logic [1:0]         r_o_status;
    logic signed [11:0] r_o_temp;
    logic [9:0]         r_o_hum;

    logic        out_load, a_load;
    logic [10:0] q0_t, q_t;
    logic [9:0]  q0_h, q_h;
    logic [16:0] rem_t, rem_h;

    assign out_load  = r_a_valid && (!r_o_valid || i_ready);
    assign a_load    = !r_a_valid || out_load;
    assign o_job_pop = i_job_valid && a_load;

    // Division by 65535: take the quotient as p >> 16, the remainder is then
    // (p mod 65536) + q0, which stays below twice the divisor, so one
    // compare and increment finishes it.
    always_comb begin
        q0_t  = r_a_prod_t[26:16];
        rem_t = {1'b0, r_a_prod_t[15:0]} + 17'(q0_t);
        q_t   = (rem_t >= 17'(thfd_pkg::FULL_SCALE)) ? q0_t + 11'd1 : q0_t;
        q0_h  = r_a_prod_h[25:16];
        rem_h = {1'b0, r_a_prod_h[15:0]} + 17'(q0_h);
        q_h   = (rem_h >= 17'(thfd_pkg::FULL_SCALE)) ? q0_h + 10'd1 : q0_h;

        n_last_t = r_last_t;
        n_last_h = r_last_h;
        if (out_load && (r_a_status == thfd_pkg::ST_OK)) begin
            n_last_t = q_t;
            n_last_h = q_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_last_t  <= 11'd0;
            r_last_h  <= 10'd0;
        end else begin
            if (a_load) begin
                r_a_valid <= o_job_pop;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            r_last_t <= n_last_t;
            r_last_h <= n_last_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_a_status <= i_job.status;
            r_a_prod_t <= 27'(i_job.raw_temp) * 27'(thfd_pkg::TEMP_SPAN);
            r_a_prod_h <= 26'(i_job.raw_hum) * 26'(thfd_pkg::HUM_SPAN);
        end
        if (out_load) begin
            r_o_status <= r_a_status;
            r_o_temp   <= $signed(12'({1'b0, n_last_t}) - 12'(thfd_pkg::TEMP_OFFSET));
            r_o_hum    <= n_last_h;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_temp_deci   = r_o_temp;
    assign o_rh_permille = r_o_hum;

endmodule

// File: sv/temp_humidity_frame_decoder.sv
// Top level of the temperature and humidity frame decoder.
// Depends on thfd_pkg, thfd_if, thfd_front, thfd_queue and thfd_back.
`timescale 1ns / 1ps

// The decoder takes a six-byte sensor frame one item per clock on i_frame,
// while i_frame.ready is high: temperature high and low byte, their CRC-8
// (polynomial 0x31, start 0xFF), humidity high and low byte and their
// CRC-8. An item with op set reports a failed bus read; it restarts the
// frame and yields a result with status 1 right away. After the sixth byte
// one result leaves on o_result: status 0 with freshly scaled readings when
// both checks match, or status 2 with the previous good readings when
// either check fails. Temperature is given in tenths of a degree
// (1750*raw/65535 - 450) and humidity in tenths of a percent
// (1000*raw/65535); after reset they read -450 and 0. The front end
// classifies each byte combinationally, a queue of P_QUEUE_DEPTH jobs
// decouples it from the back end, and the back end registers the two
// multiplications in its product stage and the division by 65535 in its
// output register. i_frame.ready drops only when the queue is full, which
// happens after a long stall on o_result.

module temp_humidity_frame_decoder #(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    thfd_in_if.sink    i_frame,
    thfd_out_if.source o_result
);

    logic           frame_accept;
    logic           job_push;
    thfd_pkg::t_job front_job;
    thfd_pkg::t_job queue_job;
    logic           queue_full;
    logic           queue_empty;
    logic           job_pop;

    assign i_frame.ready = !queue_full;
    assign frame_accept  = i_frame.valid && i_frame.ready;

    thfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (frame_accept),
        .i_op        (i_frame.op),
        .i_data_byte (i_frame.data_byte),
        .o_push      (job_push),
        .o_job       (front_job)
    );

    thfd_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .i_pop   (job_pop),
        .o_job   (queue_job),
        .o_full  (queue_full),
        .o_empty (queue_empty)
    );

    thfd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (!queue_empty),
        .i_job         (queue_job),
        .o_job_pop     (job_pop),
        .o_valid       (o_result.valid),
        .i_ready       (o_result.ready),
        .o_status      (o_result.status),
        .o_temp_deci   (o_result.temp_deci),
        .o_rh_permille (o_result.rh_permille)
    );

    // A job is never produced while the queue has no room for it.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_push |-> !queue_full)
        else $error("job pushed into a full queue");

    // Results always carry readings inside the sensor range.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.rh_permille <= 10'd1000) &&
                           (o_result.temp_deci >= -12'sd450) &&
                           (o_result.temp_deci <= 12'sd1300))
        else $error("result reading out of range");

    // A read failure item reaches the queue in the same cycle it is taken.
    a_fail_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (frame_accept && i_frame.op) |-> job_push)
        else $error("read failure item produced no job");

    // Nothing is shown on the result channel right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_result.valid)
        else $error("result valid directly after reset");

endmodule

// File: verif/thfd_tb_pkg.sv
// Verification helpers for the frame decoder: input op codes, the reading record and CRC-8.
// Depends on thfd_pkg for the CRC polynomial.
`timescale 1ns / 1ps

package thfd_tb_pkg;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_ABORT = 1'b1;

    // One result item as the decoder should present it.
    typedef struct {
        logic [1:0]         status;
        logic signed [11:0] temp;
        logic [9:0]         hum;
    } t_reading;

    // Feeds one byte, MSB first, into a CRC-8 register.
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = (c << 1) ^ thfd_pkg::CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

// File: verif/thfd_result_checker.sv
// Checker of the frame decoder: follows accepted input items, predicts result items
// and compares them with the output channel. Depends on thfd_pkg, thfd_tb_pkg and thfd_if.
`timescale 1ns / 1ps

module thfd_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    thfd_in_if          i_frame,
    thfd_out_if         i_result,
    output int unsigned o_error_count,
    output int unsigned o_pending,
    output int unsigned o_ok_count,
    output int unsigned o_read_fail_count,
    output int unsigned o_crc_bad_count
);

    logic [2:0]  byte_pos;
    logic [7:0]  word_crc;
    logic        temp_crc_ok;
    logic [15:0] temp_word;
    logic [15:0] hum_word;
    logic [10:0] good_temp;   // newest good temperature plus the offset
    logic [9:0]  good_hum;
    thfd_tb_pkg::t_reading readings_due[$];

    task automatic report_failure(input string msg);
        o_error_count++;
        $display("[%0t] result check: %s", $time, msg);
    endtask

    task automatic restart_frame();
        byte_pos    = 3'd0;
        word_crc    = thfd_pkg::CRC_INIT;
        temp_crc_ok = 1'b0;
    endtask

    task automatic push_reading(input logic [1:0] status);
        thfd_tb_pkg::t_reading r;
        r.status = status;
        r.temp   = $signed(12'(good_temp) - 12'(thfd_pkg::TEMP_OFFSET));
        r.hum    = good_hum;
        readings_due.push_back(r);
        case (status)
            thfd_pkg::ST_OK:        o_ok_count++;
            thfd_pkg::ST_READ_FAIL: o_read_fail_count++;
            default:                o_crc_bad_count++;
        endcase
    endtask

    task automatic decode_item(input logic op, input logic [7:0] b);
        logic [2:0] pos;
        logic       frame_ok;
        pos = byte_pos;
        if (op == thfd_tb_pkg::OP_ABORT) begin
            restart_frame();
            push_reading(thfd_pkg::ST_READ_FAIL);
            return;
        end
        if (pos > 3'd5) begin
            restart_frame();
            pos = 3'd0;
        end
        byte_pos = pos + 3'd1;
        case (pos)
            3'd0: begin
                word_crc        = thfd_tb_pkg::crc8_feed(thfd_pkg::CRC_INIT, b);
                temp_word[15:8] = b;
            end
            3'd1: begin
                word_crc       = thfd_tb_pkg::crc8_feed(word_crc, b);
                temp_word[7:0] = b;
            end
            3'd2: begin
                temp_crc_ok = (word_crc == b);
                word_crc    = thfd_pkg::CRC_INIT;
            end
            3'd3: begin
                word_crc       = thfd_tb_pkg::crc8_feed(thfd_pkg::CRC_INIT, b);
                hum_word[15:8] = b;
            end
            3'd4: begin
                word_crc      = thfd_tb_pkg::crc8_feed(word_crc, b);
                hum_word[7:0] = b;
            end
            default: begin
                frame_ok = temp_crc_ok && (word_crc == b);
                restart_frame();
                if (frame_ok) begin
                    good_temp = 11'((thfd_pkg::TEMP_SPAN * 32'(temp_word))
                                    / thfd_pkg::FULL_SCALE);
                    good_hum  = 10'((thfd_pkg::HUM_SPAN * 32'(hum_word))
                                    / thfd_pkg::FULL_SCALE);
                    push_reading(thfd_pkg::ST_OK);
                end else begin
                    push_reading(thfd_pkg::ST_CRC_BAD);
                end
            end
        endcase
    endtask

    task automatic check_result();
        thfd_tb_pkg::t_reading want;
        if (readings_due.size() == 0) begin
            report_failure($sformatf("unexpected result: status %0d temp %0d hum %0d",
                i_result.status, i_result.temp_deci, i_result.rh_permille));
            return;
        end
        want = readings_due.pop_front();
        if (i_result.status !== want.status) begin
            report_failure($sformatf("status %0d, expected %0d", i_result.status, want.status));
        end
        if (i_result.temp_deci !== want.temp) begin
            report_failure($sformatf("temperature %0d, expected %0d",
                i_result.temp_deci, want.temp));
        end
        if (i_result.rh_permille !== want.hum) begin
            report_failure($sformatf("humidity %0d, expected %0d",
                i_result.rh_permille, want.hum));
        end
    endtask

    // Values are read before the edge updates anything, so both channels
    // are seen as they stood when the handshakes happened.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_frame();
            temp_word = '0;
            hum_word  = '0;
            good_temp = '0;
            good_hum  = '0;
            readings_due.delete();
        end else begin
            if (i_frame.valid && i_frame.ready) begin
                decode_item(i_frame.op, i_frame.data_byte);
            end
            if (i_result.valid && i_result.ready) begin
                check_result();
            end
        end
        o_pending = readings_due.size();
    end

endmodule

// File: verif/tb_temp_humidity_frame_decoder.sv
// Testbench top of the frame decoder: clock, reset, stimulus, receiver and verdict.
// Depends on thfd_pkg, thfd_tb_pkg, thfd_if, thfd_result_checker and the decoder itself.
`timescale 1ns / 1ps

module tb_temp_humidity_frame_decoder;

    // Number of random items per idling phase; three phases give about 1950.
    localparam int unsigned PHASE_ITEMS  = 650;
    // Length of the long stall on the result channel that fills the job queue.
    localparam int unsigned HOLD_CYCLES  = 300;
    // Cycles without any handshake after which the run is declared hung.
    localparam int unsigned QUIET_LIMIT  = 3000;
    // Cycles left to run after the last expected result, to catch extras.
    localparam int unsigned DRAIN_CYCLES = 12;

    logic i_clk;
    logic i_rst_n;

    thfd_in_if  frame_ch ();
    thfd_out_if result_ch ();

    int unsigned error_count;
    int unsigned pending;
    int unsigned ok_count;
    int unsigned read_fail_count;
    int unsigned crc_bad_count;

    int unsigned items_sent;
    int unsigned tx_idle_pct;   // owned by the stimulus process
    int unsigned rx_idle_pct;   // nonblocking updates in the phases, read by the receiver
    int unsigned hold_req;      // each increment asks the receiver for one long stall

    temp_humidity_frame_decoder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_ch),
        .o_result (result_ch)
    );

    thfd_result_checker checker_inst (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_frame           (frame_ch),
        .i_result          (result_ch),
        .o_error_count     (error_count),
        .o_pending         (pending),
        .o_ok_count        (ok_count),
        .o_read_fail_count (read_fail_count),
        .o_crc_bad_count   (crc_bad_count)
    );

    // 12 ns clock, low half first so the first rising edge comes after the
    // inputs have been given known values at time zero.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Offers one item at a falling edge, after a random number of idle
    // cycles, and holds it until the decoder accepts it at a rising edge.
    // While idle the payload carries junk, which the decoder must ignore.
    task automatic send_byte(input logic op, input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            frame_ch.valid     <= 1'b0;
            frame_ch.op        <= 1'($urandom);
            frame_ch.data_byte <= 8'($urandom);
            @(negedge i_clk);
        end
        frame_ch.valid     <= 1'b1;
        frame_ch.op        <= op;
        frame_ch.data_byte <= b;
        do @(posedge i_clk); while (!frame_ch.ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Sends one measurement frame. Either check byte may be corrupted on
    // purpose. With cut below six, only that many bytes go out and a read
    // failure item ends the frame early.
    task automatic send_frame(input logic [15:0] tw, input logic [15:0] hw,
                              input bit temp_crc_good, input bit hum_crc_good,
                              input int unsigned cut);
        logic [7:0] frame_bytes[6];
        logic [7:0] tc;
        logic [7:0] hc;
        tc = thfd_tb_pkg::crc8_feed(thfd_tb_pkg::crc8_feed(thfd_pkg::CRC_INIT, tw[15:8]),
                                    tw[7:0]);
        hc = thfd_tb_pkg::crc8_feed(thfd_tb_pkg::crc8_feed(thfd_pkg::CRC_INIT, hw[15:8]),
                                    hw[7:0]);
        if (!temp_crc_good) begin
            tc ^= 8'($urandom_range(1, 255));
        end
        if (!hum_crc_good) begin
            hc ^= 8'($urandom_range(1, 255));
        end
        frame_bytes = '{tw[15:8], tw[7:0], tc, hw[15:8], hw[7:0], hc};
        for (int k = 0; k < 6 && k < cut; k++) begin
            send_byte(thfd_tb_pkg::OP_BYTE, frame_bytes[k]);
        end
        if (cut < 6) begin
            send_byte(thfd_tb_pkg::OP_ABORT, 8'($urandom));
        end
    endtask

    // Raw sensor words lean toward the ends of the scale now and then.
    function automatic logic [15:0] pick_word();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // One random sequence. Most are complete frames with random words and
    // mostly good check bytes; the rest are frames cut short by a read
    // failure, bursts of stray bytes resynchronized by a read failure, and
    // lone read failures.
    task automatic random_sequence();
        int unsigned kind;
        kind = $urandom_range(99);
        if (kind < 70) begin
            send_frame(pick_word(), pick_word(), $urandom_range(99) < 85,
                       $urandom_range(99) < 85, 6);
        end else if (kind < 82) begin
            send_frame(pick_word(), pick_word(), 1'b1, 1'b1, $urandom_range(5));
        end else if (kind < 92) begin
            repeat ($urandom_range(1, 8)) send_byte(thfd_tb_pkg::OP_BYTE, 8'($urandom));
            send_byte(thfd_tb_pkg::OP_ABORT, 8'($urandom));
        end else begin
            send_byte(thfd_tb_pkg::OP_ABORT, 8'($urandom));
        end
    endtask

    // Result receiver. It stalls at random at the current rate, and on
    // request holds ready low for a long stretch that it counts itself,
    // while the stimulus keeps offering items until the decoder backs up.
    initial begin : result_receiver
        int unsigned hold_left;
        int unsigned hold_seen;
        hold_left       = 0;
        hold_seen       = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: a run in which no item moves on either channel for too long
    // is hung, whether by a lost result or by a stuck handshake.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int unsigned phase_end;
        i_rst_n            = 1'b0;
        frame_ch.valid     = 1'b0;
        frame_ch.op        = thfd_tb_pkg::OP_BYTE;
        frame_ch.data_byte = 8'h00;
        items_sent         = 0;
        tx_idle_pct        = 28;
        rx_idle_pct        = 49;
        hold_req           = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. A read failure straight after reset reports the
        // reset readings of -450 and 0.
        send_byte(thfd_tb_pkg::OP_ABORT, 8'h00);
        // Full-scale words give the top of both ranges.
        send_frame(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 6);
        // A bad temperature check must keep the previous good readings.
        send_frame(16'h1234, 16'hFFFF, 1'b0, 1'b1, 6);
        // A bad humidity check alone must fail the frame too.
        send_frame(16'h0000, 16'h8000, 1'b1, 1'b0, 6);
        // A read failure after one byte restarts the frame; its data byte
        // is ignored.
        send_frame(16'hA5A5, 16'h5A5A, 1'b1, 1'b1, 1);
        // Zero words give the bottom of both ranges as fresh readings.
        send_frame(16'h0000, 16'h0000, 1'b1, 1'b1, 6);

        // Random part in three idling phases: sender idles less than the
        // receiver, then the other way round, then neither idles. The last
        // two phases open with a long stall on the result side.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 28;
                    rx_idle_pct <= 49;
                end
                1: begin
                    tx_idle_pct = 49;
                    rx_idle_pct <= 28;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
            endcase
            if (ph > 0) begin
                hold_req <= hold_req + 1;
            end
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                random_sequence();
            end
        end

        // Drain: wait for every expected result, then a few cycles more so
        // that a spurious extra result would still be seen.
        frame_ch.valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d input items under three idling mixes with long output stalls.",
                 items_sent);
        $display("Results: %0d good frames, %0d read failures, %0d check mismatches, %0d errors.",
                 ok_count, read_fail_count, crc_bad_count, error_count);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/thfd_pkg.sv
sv/thfd_if.sv
sv/thfd_front.sv
sv/thfd_queue.sv
sv/thfd_back.sv
sv/temp_humidity_frame_decoder.sv
verif/thfd_tb_pkg.sv
verif/thfd_result_checker.sv
verif/tb_temp_humidity_frame_decoder.sv
